// ===== rtl/core/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg: shared definitions for the sumset / difference-set classifier
// Widths, lane geometry, register indexes, class codes and the control
// structs passed between the lane, merge and top-level modules.
// ----------------------------------------------------------------------------
package sdc_pkg;

    // Universe and map geometry
    localparam int SET_W   = 64;                  // positions in the universe
    localparam int SMAP_W  = 2 * SET_W;           // sum map indices 0..2*SET_W-1
    localparam int LANE_W  = 8;                   // positions handled per lane
    localparam int LANES   = SET_W / LANE_W;      // number of parallel lanes
    localparam int LSUM_W  = LANE_W + SET_W - 1;  // lane-local sum map width
    localparam int NUM_W   = 7;                   // size, fringe and thresholds
    localparam int CNT_W   = 7;                   // result counts
    localparam int CLASS_W = 2;

    // Byte-wise popcount layout used by the merge stage
    localparam int BYTE_W   = 8;
    localparam int BCNT_W   = 4;                  // 0..8 per byte
    localparam int SBYTES   = SMAP_W / BYTE_W;    // bytes of the sum map
    localparam int DBYTES   = SET_W / BYTE_W;     // bytes of one diff map
    localparam int NCNT     = SBYTES;             // partial counts per total
    localparam int TREE_W   = 8;                  // tree result, up to 128

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_SIZE      = 3'd0,
        CFG_FRINGE_WIDTH  = 3'd1,
        CFG_REMOVE_ENABLE = 3'd2,
        CFG_REMOVE_LOW    = 3'd3,
        CFG_REMOVE_HIGH   = 3'd4
    } t_cfg_index;

    // Output class codes
    localparam logic [CLASS_W-1:0] CLS_MORE_SUMS  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_BALANCED   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_MORE_DIFFS = 2'd2;

    // Counting window derived from the configuration
    typedef struct packed {
        logic [NUM_W-1:0] f;    // low sum window: index below f
        logic [NUM_W-1:0] u;    // high sum window: index at or above u
        logic [NUM_W-1:0] t1;   // positive differences counted from t1 up
        logic [NUM_W-1:0] t2;   // negative differences counted from t2 up
    } t_window;

    // Stage loads for the merge unit
    typedef struct packed {
        logic en_cnt;           // load byte counts
        logic en_tot;           // load totals
    } t_merge_ctrl;

    typedef logic [LANES-1:0][LSUM_W-1:0] t_sum_bus;
    typedef logic [LANES-1:0][SET_W-1:0]  t_diff_bus;
    typedef logic [NCNT-1:0][BCNT_W-1:0]  t_cnt_vec;

    // Thermometer mask: bit i set when i < x
    function automatic logic [SET_W-1:0] low_mask(input logic [NUM_W-1:0] x);
        logic [SET_W-1:0] m;
        for (int i = 0; i < SET_W; i++) begin
            m[i] = (NUM_W'(i) < x);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/sdc_lane.sv =====
// ----------------------------------------------------------------------------
// sdc_lane: one lane of pair marking
// Marks the sums and positive differences of every pair whose lower member
// lies in this lane's eight positions. Maps are lane-local and registered.
// ----------------------------------------------------------------------------
module sdc_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [sdc_pkg::SET_W-1:0]  i_set,       // whole member set
    input  logic [sdc_pkg::SET_W-1:0]  i_tail,      // set shifted to lane base
    output logic [sdc_pkg::LSUM_W-1:0] o_sum_part,  // sums, offset by lane base
    output logic [sdc_pkg::SET_W-1:0]  o_diff_part  // differences 0..63
);

    logic [sdc_pkg::LSUM_W-1:0] n_sum;
    logic [sdc_pkg::SET_W-1:0]  n_diff;
    logic [sdc_pkg::LSUM_W-1:0] r_sum;
    logic [sdc_pkg::SET_W-1:0]  r_diff;

    // Sum map: lane member i with any member j lands at i + j
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < sdc_pkg::LANE_W; i++) begin
            for (int j = 0; j < sdc_pkg::SET_W; j++) begin
                n_sum[i+j] = n_sum[i+j] | (i_tail[i] & i_set[j]);
            end
        end
    end

    // Difference map: lane member i with member i + d
    always_comb begin
        n_diff = '0;
        for (int d = 0; d < sdc_pkg::SET_W; d++) begin
            for (int i = 0; i < sdc_pkg::LANE_W; i++) begin
                if (i + d < sdc_pkg::SET_W) begin
                    n_diff[d] = n_diff[d] | (i_tail[i] & i_tail[i+d]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_diff <= n_diff;
        end
    end

    assign o_sum_part  = r_sum;
    assign o_diff_part = r_diff;

endmodule

// ===== rtl/core/sdc_merge.sv =====
// ----------------------------------------------------------------------------
// sdc_merge: lane merge and counting
// ORs the lane maps into the full sum and difference maps, applies the
// counting window, takes byte popcounts, then adds them in a small tree.
// ----------------------------------------------------------------------------
module sdc_merge (
    input  logic                      i_clk,
    input  sdc_pkg::t_merge_ctrl      i_ctrl,
    input  sdc_pkg::t_window          i_window,
    input  sdc_pkg::t_sum_bus         i_sum_bus,
    input  sdc_pkg::t_diff_bus        i_diff_bus,
    output logic [sdc_pkg::CNT_W-1:0] o_sum_total,
    output logic [sdc_pkg::CNT_W-1:0] o_diff_total
);

    logic [sdc_pkg::SMAP_W-1:0] w_smap;
    logic [sdc_pkg::SET_W-1:0]  w_dmap;
    logic [sdc_pkg::SMAP_W-1:0] w_sm;
    logic [sdc_pkg::SET_W-1:0]  w_dpos;
    logic [sdc_pkg::SET_W-1:0]  w_dneg;
    sdc_pkg::t_cnt_vec          n_scnt;
    sdc_pkg::t_cnt_vec          n_dcnt;
    sdc_pkg::t_cnt_vec          r_scnt;
    sdc_pkg::t_cnt_vec          r_dcnt;
    logic [sdc_pkg::TREE_W-1:0] w_stree;
    logic [sdc_pkg::TREE_W-1:0] w_dtree;
    logic [sdc_pkg::CNT_W-1:0]  r_sum;
    logic [sdc_pkg::CNT_W-1:0]  r_diff;

    function automatic logic [sdc_pkg::BCNT_W-1:0] pop8(
        input logic [sdc_pkg::BYTE_W-1:0] b
    );
        logic [sdc_pkg::BCNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < sdc_pkg::BYTE_W; i++) begin
            c = c + sdc_pkg::BCNT_W'(b[i]);
        end
        return c;
    endfunction

    // Four-level adder tree over sixteen byte counts
    function automatic logic [sdc_pkg::TREE_W-1:0] tree16(input sdc_pkg::t_cnt_vec c);
        logic [4:0] l1 [8];
        logic [5:0] l2 [4];
        logic [6:0] l3 [2];
        for (int i = 0; i < 8; i++) begin
            l1[i] = 5'(c[2*i]) + 5'(c[2*i+1]);
        end
        for (int i = 0; i < 4; i++) begin
            l2[i] = 6'(l1[2*i]) + 6'(l1[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            l3[i] = 7'(l2[2*i]) + 7'(l2[2*i+1]);
        end
        return sdc_pkg::TREE_W'(l3[0]) + sdc_pkg::TREE_W'(l3[1]);
    endfunction

    // Merge lanes: sum maps sit at the lane base, difference maps align
    always_comb begin
        w_smap = '0;
        w_dmap = '0;
        for (int l = 0; l < sdc_pkg::LANES; l++) begin
            w_smap = w_smap | (sdc_pkg::SMAP_W'(i_sum_bus[l]) << (l * sdc_pkg::LANE_W));
            w_dmap = w_dmap | i_diff_bus[l];
        end
    end

    // Counting windows
    always_comb begin
        for (int k = 0; k < sdc_pkg::SMAP_W; k++) begin
            w_sm[k] = w_smap[k] & !((8'(k) >= {1'b0, i_window.f}) &&
                                    (8'(k) <  {1'b0, i_window.u}));
        end
        for (int d = 0; d < sdc_pkg::SET_W; d++) begin
            w_dpos[d] = w_dmap[d] & (sdc_pkg::NUM_W'(d) >= i_window.t1);
            w_dneg[d] = w_dmap[d] & (sdc_pkg::NUM_W'(d) >= i_window.t2);
        end
    end

    // Byte popcounts
    always_comb begin
        for (int b = 0; b < sdc_pkg::SBYTES; b++) begin
            n_scnt[b] = pop8(w_sm[b*sdc_pkg::BYTE_W +: sdc_pkg::BYTE_W]);
        end
        for (int b = 0; b < sdc_pkg::DBYTES; b++) begin
            n_dcnt[b]                  = pop8(w_dpos[b*sdc_pkg::BYTE_W +: sdc_pkg::BYTE_W]);
            n_dcnt[sdc_pkg::DBYTES+b]  = pop8(w_dneg[b*sdc_pkg::BYTE_W +: sdc_pkg::BYTE_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_cnt) begin
            r_scnt <= n_scnt;
            r_dcnt <= n_dcnt;
        end
    end

    // Totals
    assign w_stree = tree16(r_scnt);
    assign w_dtree = tree16(r_dcnt);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_tot) begin
            r_sum  <= w_stree[sdc_pkg::CNT_W-1:0];
            r_diff <= w_dtree[sdc_pkg::CNT_W-1:0];
        end
    end

    assign o_sum_total  = r_sum;
    assign o_diff_total = r_diff;

endmodule

// ===== rtl/core/sumset_diffset_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// sumset_diffset_classifier_unit: sumset / difference-set classifier
// A result passes the prep, lane marking, byte count, totals and output
// registers. One request per cycle unless the result stream stalls;
// eight lanes mark all pairs in parallel.
// Reset (synchronous, active low) empties the pipeline and loads set_size 64,
// all other config registers 0. The config port is always ready.
// ----------------------------------------------------------------------------
module sumset_diffset_classifier_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [sdc_pkg::SET_W-1:0]     i_s_axis_tdata,  // [63:0] member_bits
    // Result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [15:0]                   o_m_axis_tdata,  // [6:0] sum_total,
                                                           // [13:7] diff_total,
                                                           // [15:14] set_class
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [6:0] r_set_size;
    logic [5:0] r_fringe_width;
    logic       r_remove_enable;
    logic [5:0] r_remove_low;
    logic [5:0] r_remove_high;

    // Derived configuration
    logic [sdc_pkg::NUM_W-1:0] w_n;
    logic [sdc_pkg::NUM_W-1:0] w_f;
    logic [sdc_pkg::NUM_W-1:0] w_nmf;
    logic [sdc_pkg::NUM_W-1:0] w_dist;
    logic [7:0]                w_upper;
    logic                      w_remove;
    sdc_pkg::t_window          w_window;

    // Prep path
    logic [sdc_pkg::SET_W-1:0] w_a0;
    logic [sdc_pkg::SET_W-1:0] w_a1;
    logic [sdc_pkg::SET_W-1:0] w_afr;
    logic [sdc_pkg::SET_W-1:0] r_set;

    // Pipeline control
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    sdc_pkg::t_merge_ctrl w_mctrl;

    // Lane and merge signals
    sdc_pkg::t_sum_bus          w_sum_bus;
    sdc_pkg::t_diff_bus         w_diff_bus;
    logic [sdc_pkg::CNT_W-1:0]  w_sum_total;
    logic [sdc_pkg::CNT_W-1:0]  w_diff_total;
    logic [sdc_pkg::CLASS_W-1:0] w_class;

    // Output register
    logic [sdc_pkg::CNT_W-1:0]   r_sum_out;
    logic [sdc_pkg::CNT_W-1:0]   r_diff_out;
    logic [sdc_pkg::CLASS_W-1:0] r_class;

    // Config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size      <= 7'd64;
            r_fringe_width  <= '0;
            r_remove_enable <= 1'b0;
            r_remove_low    <= '0;
            r_remove_high   <= '0;
        end else if (i_cfg_valid) begin
            unique case (sdc_pkg::t_cfg_index'(i_cfg_index))
                sdc_pkg::CFG_SET_SIZE:      r_set_size      <= i_cfg_data[6:0];
                sdc_pkg::CFG_FRINGE_WIDTH:  r_fringe_width  <= i_cfg_data[5:0];
                sdc_pkg::CFG_REMOVE_ENABLE: r_remove_enable <= i_cfg_data[0];
                sdc_pkg::CFG_REMOVE_LOW:    r_remove_low    <= i_cfg_data[5:0];
                sdc_pkg::CFG_REMOVE_HIGH:   r_remove_high   <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Effective size, fringe (zero fringe means the whole set) and thresholds
    always_comb begin
        if (r_set_size == '0) begin
            w_n = sdc_pkg::NUM_W'(1);
        end else if (r_set_size > sdc_pkg::NUM_W'(sdc_pkg::SET_W)) begin
            w_n = sdc_pkg::NUM_W'(sdc_pkg::SET_W);
        end else begin
            w_n = r_set_size;
        end
        if (r_fringe_width == '0 || {1'b0, r_fringe_width} > w_n) begin
            w_f = w_n;
        end else begin
            w_f = {1'b0, r_fringe_width};
        end
        w_nmf   = w_n - w_f;
        w_upper = {w_n, 1'b0} - {1'b0, w_f} - 8'd1;
        w_window.f  = w_f;
        w_window.u  = (w_upper[6:0] > w_f) ? w_upper[6:0] : w_f;
        w_window.t1 = (w_nmf == '0) ? '0 : w_nmf - sdc_pkg::NUM_W'(1);
        w_window.t2 = w_nmf + sdc_pkg::NUM_W'(1);
        w_remove = r_remove_enable && (r_remove_low <= r_remove_high);
        w_dist   = {1'b0, r_remove_high} - {1'b0, r_remove_low} + sdc_pkg::NUM_W'(1);
    end

    // Prep: trim to size, close the removed range, keep the fringes
    always_comb begin
        w_a0 = i_s_axis_tdata & sdc_pkg::low_mask(w_n);
        if (w_remove) begin
            w_a1 = (w_a0 & sdc_pkg::low_mask({1'b0, r_remove_low})) |
                   ((w_a0 >> w_dist) & ~sdc_pkg::low_mask({1'b0, r_remove_low}));
        end else begin
            w_a1 = w_a0;
        end
        w_afr = w_a1 & (sdc_pkg::low_mask(w_f) | ~sdc_pkg::low_mask(w_nmf));
    end

    // Ready chain: a stage loads when empty or when the next one loads
    assign w_rdy4 = !r_v4 || i_m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign o_s_axis_tready = w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_s_axis_tvalid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Prepared set register
    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_s_axis_tvalid) begin
            r_set <= w_afr;
        end
    end

    // Marking lanes
    for (genvar l = 0; l < sdc_pkg::LANES; l++) begin : g_lane
        sdc_lane u_lane (
            .i_clk       (i_clk),
            .i_en        (w_rdy1 && r_v0),
            .i_set       (r_set),
            .i_tail      (r_set >> (l * sdc_pkg::LANE_W)),
            .o_sum_part  (w_sum_bus[l]),
            .o_diff_part (w_diff_bus[l])
        );
    end

    // Merge and count
    assign w_mctrl.en_cnt = w_rdy2 && r_v1;
    assign w_mctrl.en_tot = w_rdy3 && r_v2;

    sdc_merge u_merge (
        .i_clk        (i_clk),
        .i_ctrl       (w_mctrl),
        .i_window     (w_window),
        .i_sum_bus    (w_sum_bus),
        .i_diff_bus   (w_diff_bus),
        .o_sum_total  (w_sum_total),
        .o_diff_total (w_diff_total)
    );

    // Classify
    always_comb begin
        priority if (w_sum_total > w_diff_total) begin
            w_class = sdc_pkg::CLS_MORE_SUMS;
        end else if (w_sum_total == w_diff_total) begin
            w_class = sdc_pkg::CLS_BALANCED;
        end else begin
            w_class = sdc_pkg::CLS_MORE_DIFFS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r_sum_out  <= w_sum_total;
            r_diff_out <= w_diff_total;
            r_class    <= w_class;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {r_class, r_diff_out, r_sum_out};

endmodule
